// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/vtsf_pkg.sv =====
// Types, codes and helper functions of the volume tent smoothing filter.
package vtsf_pkg;

  localparam int CNT_W = 25;
  localparam int NUM_W = 29;
  localparam int DEN_W = 14;
  localparam int ACC_W = 29;
  localparam int WSUM_W = 13;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ACT_STORE   = 2'd0;
  localparam logic [1:0] ACT_REQUEST = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NOT_LOADED = 2'd1;
  localparam logic [1:0] STATUS_EMITTED    = 2'd2;

  localparam logic [1:0] REG_SIZE_X       = 2'd0;
  localparam logic [1:0] REG_SIZE_Y       = 2'd1;
  localparam logic [1:0] REG_SIZE_Z       = 2'd2;
  localparam logic [1:0] REG_WINDOW_WIDTH = 2'd3;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_REQUEST,
    CMD_RESTART
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] smoothed;
    logic [1:0]         status;
    logic               last;
  } out_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic signed [15:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [8:0] size_x;
    logic [8:0] size_y;
    logic [8:0] size_z;
    logic [2:0] window_width;
  } cfg_t;

  function automatic logic [8:0] eff_size(logic [8:0] s);
    logic [8:0] r;
    if (s == 9'd0) r = 9'd1;
    else if (s > 9'd256) r = 9'd256;
    else r = s;
    return r;
  endfunction

  function automatic logic [2:0] tent_weight(logic [2:0] k, logic [1:0] h);
    logic [2:0] hh;
    logic [2:0] d;
    hh = {1'b0, h};
    d = (hh > k) ? (hh - k) : (k - hh);
    return hh + 3'd1 - d;
  endfunction

endpackage

// ===== src/volume_tent_smoothing_filter.sv =====
// Volume tent smoothing filter: loads a voxel volume and emits its smoothed voxels in
// raster order. The back end takes a store or restart beat whenever it is idle. A request
// that cannot be served is answered with a status beat. A served request walks the w*w*w
// window taps through a six-stage address, memory read and multiply-accumulate pipeline
// at one tap a cycle, then a bit-serial divider forms the rounded mean. The voxel memory
// holds VOXEL_CAPACITY entries with one write and one read port, and its contents need no
// clearing after reset.
module volume_tent_smoothing_filter import vtsf_pkg::*; #(
  parameter int VOXEL_CAPACITY = 262144,
  parameter int MAX_WIDTH = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic q_full, push, q_valid, pop;
  cmd_t push_cmd, pop_cmd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE_X:       cfg_d.size_x = cfg_data_i;
        REG_SIZE_Y:       cfg_d.size_y = cfg_data_i;
        REG_SIZE_Z:       cfg_d.size_z = cfg_data_i;
        REG_WINDOW_WIDTH: cfg_d.window_width = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x       <= 9'd64;
      cfg_q.size_y       <= 9'd64;
      cfg_q.size_z       <= 9'd64;
      cfg_q.window_width <= 3'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vtsf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  vtsf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (pop_cmd)
  );

  vtsf_back #(
    .VOXEL_CAPACITY(VOXEL_CAPACITY),
    .MAX_WIDTH     (MAX_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(q_valid),
    .cmd_i      (pop_cmd),
    .cmd_pop_o  (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== src/vtsf_front.sv =====
// Front end: accepts input beats and classifies them into commands.
module vtsf_front import vtsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  input  logic q_full_i,
  output logic push_o,
  output cmd_t cmd_o
);

  logic cmd_valid_q, cmd_valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;
  logic known;

  assign push_o     = cmd_valid_q & ~q_full_i;
  assign in_stall_o = cmd_valid_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign cmd_o      = cmd_q;

  always_comb begin
    known = 1'b1;
    cmd_d = cmd_q;
    cmd_d.sample = in_data_i.sample;
    unique case (in_data_i.action)
      ACT_STORE:   cmd_d.kind = CMD_STORE;
      ACT_REQUEST: cmd_d.kind = CMD_REQUEST;
      ACT_RESTART: cmd_d.kind = CMD_RESTART;
      default: begin
        cmd_d.kind = CMD_STORE;
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (accept) begin
      cmd_valid_d = known;
    end else if (push_o) begin
      cmd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== src/vtsf_queue.sv =====
// Short command queue between front end and back end.
module vtsf_queue import vtsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            ent_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FW-1:0]   fill_q, fill_d;

  assign full_o  = (fill_q == FW'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = ent_q[rd_q];

  always_comb begin
    wr_d   = push_i ? wr_q + PW'(1) : wr_q;
    rd_d   = pop_i ? rd_q + PW'(1) : rd_q;
    fill_d = fill_q + FW'(push_i) - FW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/vtsf_div.sv =====
// Restoring divider, one quotient bit per cycle.
module vtsf_div import vtsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial  = {rem_q, quo_q[NUM_W-1]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NUM_W);
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

endmodule

// ===== src/vtsf_back.sv =====
// Back end: voxel memory, counters, tap pipeline and result register.
module vtsf_back import vtsf_pkg::*; #(
  parameter int VOXEL_CAPACITY = 262144,
  parameter int MAX_WIDTH = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int AW = (VOXEL_CAPACITY > 1) ? $clog2(VOXEL_CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(VOXEL_CAPACITY);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state_q, state_d;

  logic [8:0] sx, sy, sz;
  logic [2:0] w, wm1;
  logic [1:0] h;
  logic [17:0] prod_xy_q;
  logic [26:0] total_full;
  logic [CNT_W-1:0] total_q;

  logic [CNT_W-1:0] load_q, load_d, emit_q, emit_d;
  logic [7:0] ex_q, ex_d, ey_q, ey_d, ez_q, ez_d;

  logic [2:0] a_q, a_d, b_q, b_d, c_q, c_d;

  logic signed [9:0] zi, yi, xi;
  logic inr;
  logic [2:0] wx, wy, wz;

  logic s1_v_q, s1_inr_q;
  logic [7:0] s1_z_q, s1_y_q, s1_x_q;
  logic [4:0] s1_wyz_q;
  logic [2:0] s1_wx_q;
  logic s2_v_q;
  logic [16:0] s2_t_q;
  logic [7:0] s2_x_q;
  logic [6:0] s2_wt_q;
  logic s3_v_q;
  logic [CNT_W-1:0] s3_idx_q;
  logic [6:0] s3_wt_q;
  logic s4_v_q;
  logic [6:0] s4_wt_q;
  logic signed [15:0] rd_q;
  logic s5_v_q;
  logic [6:0] s5_wt_q;
  logic signed [22:0] s5_prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [WSUM_W-1:0] wsum_q;
  logic acc_clr;
  logic pipe_busy;

  logic [15:0] mem [VOXEL_CAPACITY];
  logic mem_we;

  logic div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;
  logic [ACC_W-1:0] mag;
  logic neg_q, last_q, last_d;
  logic [15:0] q16;

  out_t res_q, res_d;
  logic out_valid_q, out_valid_d;
  out_t out_q;
  logic out_load;

  assign sx = eff_size(cfg_i.size_x);
  assign sy = eff_size(cfg_i.size_y);
  assign sz = eff_size(cfg_i.size_z);

  always_comb begin
    if (cfg_i.window_width == 3'd0) w = 3'd1;
    else if (int'(cfg_i.window_width) > MAX_WIDTH) w = 3'(MAX_WIDTH);
    else w = cfg_i.window_width;
  end
  assign wm1 = w - 3'd1;
  assign h   = w[2:1];

  assign total_full = prod_xy_q * {18'd0, sz};

  always_ff @(posedge clk_i) begin
    prod_xy_q <= {9'd0, sx} * {9'd0, sy};
    total_q   <= total_full[CNT_W-1:0];
  end

  assign cmd_pop_o = (state_q == ST_IDLE) & cmd_valid_i;
  assign mem_we = cmd_pop_o & (cmd_i.kind == CMD_STORE) & (load_q < total_q) & (load_q < CAP);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[load_q[AW-1:0]] <= cmd_i.sample;
    end
    rd_q <= mem[s3_idx_q[AW-1:0]];
  end

  assign zi = $signed({2'b00, ez_q}) + $signed({7'd0, c_q}) - $signed({8'd0, h});
  assign yi = $signed({2'b00, ey_q}) + $signed({7'd0, b_q}) - $signed({8'd0, h});
  assign xi = $signed({2'b00, ex_q}) + $signed({7'd0, a_q}) - $signed({8'd0, h});
  assign inr = ~zi[9] & (zi[8:0] < sz) & ~yi[9] & (yi[8:0] < sy) & ~xi[9] & (xi[8:0] < sx);
  assign wx = tent_weight(a_q, h);
  assign wy = tent_weight(b_q, h);
  assign wz = tent_weight(c_q, h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      s1_v_q <= (state_q == ST_RUN);
      s2_v_q <= s1_v_q & s1_inr_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_inr_q  <= inr;
    s1_z_q    <= zi[7:0];
    s1_y_q    <= yi[7:0];
    s1_x_q    <= xi[7:0];
    s1_wyz_q  <= {2'b00, wy} * {2'b00, wz};
    s1_wx_q   <= wx;
    s2_t_q    <= {9'd0, s1_z_q} * {8'd0, sy} + {9'd0, s1_y_q};
    s2_x_q    <= s1_x_q;
    s2_wt_q   <= {2'b00, s1_wyz_q} * {4'd0, s1_wx_q};
    s3_idx_q  <= {8'd0, s2_t_q} * {16'd0, sx} + {17'd0, s2_x_q};
    s3_wt_q   <= s2_wt_q;
    s4_wt_q   <= s3_wt_q;
    s5_wt_q   <= s4_wt_q;
    s5_prod_q <= $signed({1'b0, s4_wt_q}) * rd_q;
    if (acc_clr) begin
      acc_q  <= '0;
      wsum_q <= '0;
    end else if (s5_v_q) begin
      acc_q  <= acc_q + {{(ACC_W-23){s5_prod_q[22]}}, s5_prod_q};
      wsum_q <= wsum_q + {{(WSUM_W-7){1'b0}}, s5_wt_q};
    end
  end

  assign pipe_busy = s1_v_q | s2_v_q | s3_v_q | s4_v_q | s5_v_q;

  assign mag     = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign div_num = NUM_W'({mag[ACC_W-2:0], 1'b0}) + {{(NUM_W-WSUM_W){1'b0}}, wsum_q};
  assign div_den = {wsum_q, 1'b0};
  assign q16     = div_quot[15:0];

  vtsf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign out_load = (state_q == ST_RESULT) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    state_d   = state_q;
    load_d    = load_q;
    emit_d    = emit_q;
    ex_d      = ex_q;
    ey_d      = ey_q;
    ez_d      = ez_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    res_d     = res_q;
    last_d    = last_q;
    acc_clr   = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          unique case (cmd_i.kind)
            CMD_STORE: begin
              if (mem_we) load_d = load_q + CNT_W'(1);
            end
            CMD_RESTART: begin
              load_d = '0;
              emit_d = '0;
              ex_d   = '0;
              ey_d   = '0;
              ez_d   = '0;
            end
            CMD_REQUEST: begin
              res_d = '0;
              if (load_q < total_q) begin
                res_d.status = STATUS_NOT_LOADED;
                state_d = ST_RESULT;
              end else if (emit_q >= total_q) begin
                res_d.status = STATUS_EMITTED;
                state_d = ST_RESULT;
              end else begin
                last_d  = (emit_q + CNT_W'(1) == total_q);
                acc_clr = 1'b1;
                a_d     = '0;
                b_d     = '0;
                c_d     = '0;
                state_d = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (a_q == wm1) begin
          a_d = '0;
          if (b_q == wm1) begin
            b_d = '0;
            if (c_q == wm1) state_d = ST_DRAIN;
            else c_d = c_q + 3'd1;
          end else begin
            b_d = b_q + 3'd1;
          end
        end else begin
          a_d = a_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_d.status = STATUS_OK;
          res_d.last   = last_q;
          if (wsum_q == '0) res_d.smoothed = '0;
          else if (neg_q) res_d.smoothed = -q16;
          else res_d.smoothed = q16;
          emit_d = emit_q + CNT_W'(1);
          if ({1'b0, ex_q} + 9'd1 >= sx) begin
            ex_d = '0;
            if ({1'b0, ey_q} + 9'd1 >= sy) begin
              ey_d = '0;
              if ({1'b0, ez_q} + 9'd1 >= sz) ez_d = '0;
              else ez_d = ez_q + 8'd1;
            end else begin
              ey_d = ey_q + 8'd1;
            end
          end else begin
            ex_d = ex_q + 8'd1;
          end
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_q      <= '0;
      emit_q      <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      ez_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_q      <= load_d;
      emit_q      <= emit_d;
      ex_q        <= ex_d;
      ey_q        <= ey_d;
      ez_q        <= ez_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    res_q  <= res_d;
    last_q <= last_d;
    if (div_start) neg_q <= acc_q[ACC_W-1];
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/vtsf_checker.sv =====
// Port-level checker for the volume tent smoothing filter, with its bind.
`include "assert_macros.svh"

module vtsf_checker import vtsf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input in_t        in_data_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_t       out_data_o,
  input logic       cfg_we_i
);

  logic out_wait, in_wait, refused;

  assign out_wait = out_valid_o && out_stall_i;
  assign in_wait  = in_valid_i && in_stall_o;
  assign refused  = out_valid_o && (out_data_o.status != STATUS_OK);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_data_o))
  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_wait, in_valid_i && $stable(in_data_i))
  `ASSERT_SAME(a_status_code, clk_i, rst_ni, out_valid_o, out_data_o.status <= STATUS_EMITTED)
  `ASSERT_SAME(a_refused_empty, clk_i, rst_ni, refused, out_data_o.smoothed == '0 && !out_data_o.last)
  `ASSERT_SAME(a_cfg_idle, clk_i, rst_ni, cfg_we_i, !in_valid_i && !out_valid_o)

endmodule

bind volume_tent_smoothing_filter vtsf_checker u_vtsf_checker (.*);

// ===== tb/vtsf_checker.sv =====
// Checker for the volume tent smoothing filter: predicts each result beat and compares it.
`timescale 1ns / 1ps
module vtsf_scoreboard import vtsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_t        in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_t       out_data_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_seen_o
);

  localparam int CAPACITY = 262144;

  logic [15:0] voxels [0:CAPACITY-1];
  out_t        smoothed_due [$];
  int          loaded, emitted, ex, ey, ez;
  logic [8:0]  reg_sx, reg_sy, reg_sz;
  logic [2:0]  reg_w;

  function automatic int clamp_size(logic [8:0] s);
    if (s == 0) return 1;
    if (s > 256) return 256;
    return s;
  endfunction

  function automatic logic [15:0] tent_mean(int cx, int cy, int cz, int sx, int sy, int sz);
    int     w, h, xi, yi, zi, wt;
    longint acc, wsum, mag, q;
    w = (reg_w == 0) ? 1 : reg_w;
    h = w / 2;
    acc = 0;
    wsum = 0;
    for (int c = 0; c < w; c++) begin
      zi = cz + c - h;
      if (zi < 0 || zi >= sz) continue;
      for (int b = 0; b < w; b++) begin
        yi = cy + b - h;
        if (yi < 0 || yi >= sy) continue;
        for (int a = 0; a < w; a++) begin
          xi = cx + a - h;
          if (xi < 0 || xi >= sx) continue;
          wt = (h + 1 - ((h > a) ? h - a : a - h)) * (h + 1 - ((h > b) ? h - b : b - h))
               * (h + 1 - ((h > c) ? h - c : c - h));
          wsum += wt;
          acc += longint'(wt) * longint'($signed(voxels[(zi * sy + yi) * sx + xi]));
        end
      end
    end
    if (wsum <= 0) return '0;
    mag = (acc < 0) ? -acc : acc;
    q = (2 * mag + wsum) / (2 * wsum);
    return (acc < 0) ? 16'(-q) : 16'(q);
  endfunction

  task automatic filter_step(in_t beat);
    int   sx, sy, sz, total;
    out_t r;
    sx = clamp_size(reg_sx);
    sy = clamp_size(reg_sy);
    sz = clamp_size(reg_sz);
    total = sx * sy * sz;
    r = '0;
    case (beat.action)
      ACT_STORE: begin
        if (loaded < total && loaded < CAPACITY) begin
          voxels[loaded] = beat.sample;
          loaded++;
        end
      end
      ACT_RESTART: begin
        loaded = 0;
        emitted = 0;
        ex = 0;
        ey = 0;
        ez = 0;
      end
      ACT_REQUEST: begin
        if (loaded < total) r.status = STATUS_NOT_LOADED;
        else if (emitted >= total) r.status = STATUS_EMITTED;
        else begin
          r.status = STATUS_OK;
          r.smoothed = tent_mean(ex, ey, ez, sx, sy, sz);
          r.last = (emitted + 1 == total);
          emitted++;
          ex++;
          if (ex >= sx) begin
            ex = 0;
            ey++;
            if (ey >= sy) begin
              ey = 0;
              ez++;
              if (ez >= sz) ez = 0;
            end
          end
        end
        smoothed_due = {smoothed_due, r};
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      smoothed_due.delete();
      loaded = 0;
      emitted = 0;
      ex = 0;
      ey = 0;
      ez = 0;
      reg_sx = 9'd64;
      reg_sy = 9'd64;
      reg_sz = 9'd64;
      reg_w = 3'd3;
      fail_count_o = 0;
      results_seen_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (smoothed_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result beat %p", out_data_i);
        end else begin
          want = smoothed_due.pop_front();
          if (out_data_i.smoothed !== want.smoothed || out_data_i.status !== want.status
              || out_data_i.last !== want.last) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected smoothed %0d status %0d last %0d, got %0d %0d %0d",
                       want.smoothed, want.status, want.last, out_data_i.smoothed,
                       out_data_i.status, out_data_i.last);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SIZE_X:       reg_sx = cfg_data_i;
          REG_SIZE_Y:       reg_sy = cfg_data_i;
          REG_SIZE_Z:       reg_sz = cfg_data_i;
          REG_WINDOW_WIDTH: reg_w = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) filter_step(in_data_i);
    end
    pending_o = smoothed_due.size();
  end

endmodule

// ===== tb/volume_tent_smoothing_filter_test.sv =====
// Top of the volume tent smoothing filter testbench: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module volume_tent_smoothing_filter_test import vtsf_pkg::*;;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = REG_SIZE_X;
  logic [8:0] cfg_data = '0;
  int         fail_count, pending, results_seen;
  int         beats_sent = 0;
  int         phases = 0;
  bit         bursts_on = 1'b1;
  bit         hold_off = 1'b0;

  always #2 clk_i = ~clk_i;

  volume_tent_smoothing_filter DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  vtsf_scoreboard checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall <= 1'b1;
      repeat (2000) @(posedge clk_i);
      hold_off = 1'b0;
      out_stall <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_beat(logic [1:0] act, logic [15:0] value);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, sample: value};
    do @(posedge clk_i); while (in_stall);
    beats_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_volume(logic [8:0] sx, logic [8:0] sy, logic [8:0] sz, logic [2:0] w);
    settle();
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_WINDOW_WIDTH, {6'd0, w});
    phases++;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 7)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int sx, sy, sz, total;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(ACT_REQUEST, 16'h0);
    send_beat(ACT_UNUSED, 16'hFFFF);
    set_volume(9'd0, 9'd1, 9'd1, 3'd0);
    send_beat(ACT_STORE, 16'h7FFF);
    send_beat(ACT_STORE, 16'h1234);
    send_beat(ACT_REQUEST, 16'h0);
    send_beat(ACT_REQUEST, 16'h0);
    send_beat(ACT_RESTART, 16'h0);
    send_beat(ACT_STORE, 16'h8000);
    send_beat(ACT_REQUEST, 16'h0);
    set_volume(9'h1FF, 9'd256, 9'd256, 3'd7);
    send_beat(ACT_REQUEST, 16'h0);
    set_volume(9'd2, 9'd2, 9'd2, 3'd7);
    send_beat(ACT_RESTART, 16'h0);
    for (int i = 0; i < 8; i++) send_beat(ACT_STORE, i[0] ? 16'h8000 : 16'h7FFF);
    for (int i = 0; i < 9; i++) send_beat(ACT_REQUEST, 16'h0);

    set_volume(9'd3, 9'd2, 9'd1, 3'd3);
    send_beat(ACT_RESTART, 16'h0);
    for (int i = 0; i < 6; i++) send_beat(ACT_STORE, pick_sample());
    settle();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_beat(ACT_REQUEST, 16'h0);
    settle();

    while (beats_sent < 400) begin
      if (beats_sent > 340) bursts_on = 1'b0;
      sx = $urandom_range(1, 4);
      sy = $urandom_range(1, 3);
      sz = $urandom_range(1, 3);
      if (beats_sent < 150 && $urandom_range(0, 9) == 0) sx = $urandom_range(10, 24);
      set_volume(9'(sx), 9'(sy), 9'(sz), 3'($urandom_range(0, 7)));
      total = sx * sy * sz;
      send_beat(ACT_RESTART, pick_sample());
      for (int i = 0; i < total; i++) begin
        if ($urandom_range(0, 15) == 0) send_beat(ACT_REQUEST, pick_sample());
        if ($urandom_range(0, 15) == 0) send_beat(ACT_UNUSED, pick_sample());
        send_beat(ACT_STORE, pick_sample());
      end
      if ($urandom_range(0, 3) == 0) send_beat(ACT_STORE, pick_sample());
      for (int i = 0; i < ((total > 8) ? 8 : total + 1); i++) begin
        if ($urandom_range(0, 19) == 0) send_beat(ACT_RESTART, 16'h0);
        send_beat(ACT_REQUEST, pick_sample());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (400) @(posedge clk_i);
    $display("Ran %0d input beats over %0d volume settings; %0d result beats checked.",
             beats_sent, phases, results_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
